[hw/rtl/n2a_pkg.sv]
package n2a_pkg;

  // Format codes as they arrive on the input channel.
  typedef enum logic [1:0] {
    FMT_DEC = 2'd0,
    FMT_BIN = 2'd1,
    FMT_OCT = 2'd2,
    FMT_HEX = 2'd3
  } fmt_t;

  // What a microcode step puts on the output register.
  typedef enum logic [1:0] {
    EM_NONE  = 2'd0,
    EM_LIT   = 2'd1,
    EM_DIGIT = 2'd2
  } emit_t;

  // How the step counter moves after a step.
  typedef enum logic [1:0] {
    J_NEXT     = 2'd0,
    J_LOOP     = 2'd1,
    J_DISPATCH = 2'd2,
    J_IDLE     = 2'd3
  } jump_t;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  localparam int K_W = 5;
  typedef logic [K_W-1:0] kcnt_t;

  localparam int ACC_W = 33;
  typedef logic [ACC_W-1:0] acc_t;

  // Microprogram addresses.
  localparam pc_t ST_IDLE   = 4'd0;
  localparam pc_t ST_D_B3   = 4'd1;
  localparam pc_t ST_D_B2   = 4'd2;
  localparam pc_t ST_D_B1   = 4'd3;
  localparam pc_t ST_D_B0   = 4'd4;
  localparam pc_t ST_D_EMIT = 4'd5;
  localparam pc_t ST_O_EMIT = 4'd6;
  localparam pc_t ST_B_ZERO = 4'd7;
  localparam pc_t ST_B_B    = 4'd8;
  localparam pc_t ST_B_BIT  = 4'd9;
  localparam pc_t ST_X_ZERO = 4'd10;
  localparam pc_t ST_X_X    = 4'd11;
  localparam pc_t ST_X_DIG  = 4'd12;
  localparam pc_t ST_LAST   = ST_X_DIG;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOW_B = 8'h62;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // One control word of the microprogram.
  typedef struct packed {
    emit_t      emit;    // output action
    logic [7:0] lit;     // literal character for EM_LIT
    logic       sup;     // drop a leading zero digit
    logic       trial;   // decimal restoring trial-subtract step
    logic [1:0] tbit;    // quotient bit decided by the trial
    jump_t      jump;    // sequencing
    pc_t        target;  // loop target
  } uword_t;

  function automatic pc_t entry_pc(fmt_t f);
    pc_t p;
    p = ST_IDLE;
    unique case (f)
      FMT_DEC: p = ST_D_B3;
      FMT_BIN: p = ST_B_ZERO;
      FMT_OCT: p = ST_O_EMIT;
      FMT_HEX: p = ST_X_ZERO;
      default: p = ST_IDLE;
    endcase
    return p;
  endfunction

  // Index of the most significant digit for each format.
  function automatic kcnt_t entry_k(fmt_t f);
    kcnt_t k;
    k = '0;
    unique case (f)
      FMT_DEC: k = 5'd9;
      FMT_BIN: k = 5'd31;
      FMT_OCT: k = 5'd10;
      FMT_HEX: k = 5'd7;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] digit_char(logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'b0, d};
    end else begin
      c = 8'h37 + {4'b0, d};
    end
    return c;
  endfunction

  // Trial constant (2^b) * 10^k for the decimal digit search.
  function automatic acc_t trial_const(kcnt_t k, logic [1:0] b);
    acc_t p;
    p = '0;
    unique case (k)
      5'd0:    p = 33'd1;
      5'd1:    p = 33'd10;
      5'd2:    p = 33'd100;
      5'd3:    p = 33'd1000;
      5'd4:    p = 33'd10000;
      5'd5:    p = 33'd100000;
      5'd6:    p = 33'd1000000;
      5'd7:    p = 33'd10000000;
      5'd8:    p = 33'd100000000;
      5'd9:    p = 33'd1000000000;
      default: p = '0;
    endcase
    return p << b;
  endfunction

endpackage

[hw/rtl/number_to_ascii_radix_formatter_top.sv]
// Channel  Direction  Handshake            Payload per beat
// input    in         in_valid / in_stall  value[31:0], format[1:0]
// output   out        out_valid/ out_stall character[7:0], last
//
// One number at a time: in_stall is high from acceptance until its final
// character is in the output register. Decimal takes four trial-subtract
// steps and one emit step for each of ten digit positions.
// Synchronous reset idles the step counter and empties the output register.
// An output stall holds only an emitting step.

module number_to_ascii_radix_formatter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] value,
  input  logic [1:0]  format,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  character,
  output logic        last
);

  // Sequencer state: the step counter picks a control word from the
  // microcode table; the datapath below only does what that word says.
  n2a_pkg::pc_t    pc;
  n2a_pkg::uword_t uw;

  // Working registers. acc holds the remainder in decimal and a left-shifting
  // copy of the value in the power-of-two formats; k counts digit positions.
  n2a_pkg::acc_t   acc;
  n2a_pkg::kcnt_t  k;
  n2a_pkg::fmt_t   fmt;
  logic [3:0]      q;
  logic            started;

  n2a_pkg::acc_t   tc;
  logic            ge;
  logic [3:0]      digit;
  logic            out_free;
  logic            adv;
  logic            show;
  logic            wr;
  logic            wr_last;

  n2a_ucode_rom u_rom (
    .pc (pc),
    .uw (uw)
  );

  assign in_stall = (pc != n2a_pkg::ST_IDLE);

  // The output register can take a beat if it is empty or draining now.
  assign out_free = !out_valid || !out_stall;
  assign adv      = (uw.emit == n2a_pkg::EM_NONE) || out_free;

  // Restoring trial: is the remainder at least 2^tbit * 10^k?
  assign tc = n2a_pkg::trial_const(k, uw.tbit);
  assign ge = (acc >= tc);

  // The digit on offer at an emit step, taken from the top of acc for the
  // power-of-two formats and from the quotient for decimal.
  always_comb begin
    digit = 4'd0;
    unique case (fmt)
      n2a_pkg::FMT_DEC: digit = q;
      n2a_pkg::FMT_BIN: digit = {3'b000, acc[31]};
      n2a_pkg::FMT_OCT: digit = {1'b0, acc[32:30]};
      n2a_pkg::FMT_HEX: digit = acc[31:28];
      default:          digit = 4'd0;
    endcase
  end

  // In decimal and octal, leading zeros are dropped until the first nonzero
  // digit, but the units digit always goes out: zero prints as a single '0'.
  assign show    = !uw.sup || started || (digit != 4'd0) || (k == '0);
  assign wr      = adv && ((uw.emit == n2a_pkg::EM_LIT) ||
                           ((uw.emit == n2a_pkg::EM_DIGIT) && show));
  assign wr_last = (uw.jump == n2a_pkg::J_LOOP) && (k == '0);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= n2a_pkg::ST_IDLE;
      out_valid <= 1'b0;
      started   <= 1'b0;
    end else begin
      if (wr) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (wr && (uw.emit == n2a_pkg::EM_DIGIT)) begin
        started <= 1'b1;
      end

      unique case (uw.jump)
        n2a_pkg::J_DISPATCH: begin
          if (in_valid) begin
            pc      <= n2a_pkg::entry_pc(n2a_pkg::fmt_t'(format));
            started <= 1'b0;
          end
        end
        n2a_pkg::J_NEXT: begin
          if (adv) begin
            pc <= pc + 1'b1;
          end
        end
        n2a_pkg::J_LOOP: begin
          if (adv) begin
            pc <= (k != '0) ? uw.target : n2a_pkg::ST_IDLE;
          end
        end
        n2a_pkg::J_IDLE: begin
          pc <= n2a_pkg::ST_IDLE;
        end
        default: begin
          pc <= n2a_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers; all are loaded before use, so they need no reset.
  always_ff @(posedge clk) begin
    if (wr) begin
      character <= (uw.emit == n2a_pkg::EM_LIT) ? uw.lit : n2a_pkg::digit_char(digit);
      last      <= wr_last;
    end

    if ((uw.jump == n2a_pkg::J_DISPATCH) && in_valid) begin
      acc <= {1'b0, value};
      k   <= n2a_pkg::entry_k(n2a_pkg::fmt_t'(format));
      fmt <= n2a_pkg::fmt_t'(format);
      q   <= 4'd0;
    end else begin
      if (uw.trial) begin
        q[uw.tbit] <= ge;
        if (ge) begin
          acc <= acc - tc;
        end
      end

      if (adv && (uw.jump == n2a_pkg::J_LOOP)) begin
        k <= k - 1'b1;
      end

      if (adv && (uw.emit == n2a_pkg::EM_DIGIT)) begin
        unique case (fmt)
          n2a_pkg::FMT_DEC: q   <= 4'd0;
          n2a_pkg::FMT_BIN: acc <= {acc[31:0], 1'b0};
          n2a_pkg::FMT_OCT: acc <= {acc[29:0], 3'b000};
          n2a_pkg::FMT_HEX: acc <= {acc[28:0], 4'b0000};
          default:          q   <= 4'd0;
        endcase
      end
    end
  end

  // The step counter stays within the microprogram.
  assert property (@(posedge clk) disable iff (rst) pc <= n2a_pkg::ST_LAST)
    else $error("step counter outside the microprogram");

  // Writing the final character of a number returns the sequencer to idle.
  assert property (@(posedge clk) disable iff (rst)
    (wr && wr_last) |=> (pc == n2a_pkg::ST_IDLE))
    else $error("sequencer not idle after the final character");

  // A decimal digit found by the four trials is never above nine.
  assert property (@(posedge clk) disable iff (rst)
    (pc == n2a_pkg::ST_D_EMIT) |-> (q <= 4'd9))
    else $error("decimal digit out of range");

  // A number is taken in only at idle, and once taken it starts the microprogram.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (pc != n2a_pkg::ST_IDLE))
    else $error("accepted number did not start the microprogram");

endmodule

[hw/rtl/n2a_ucode_rom.sv]
module n2a_ucode_rom (
  input  n2a_pkg::pc_t   pc,
  output n2a_pkg::uword_t uw
);

  always_comb begin
    uw = '{emit: n2a_pkg::EM_NONE, lit: n2a_pkg::CH_NUL, sup: 1'b0, trial: 1'b0,
           tbit: 2'd0, jump: n2a_pkg::J_IDLE, target: n2a_pkg::ST_IDLE};
    unique case (pc) inside
      n2a_pkg::ST_IDLE: begin
        uw.jump = n2a_pkg::J_DISPATCH;
      end
      n2a_pkg::ST_D_B3: begin
        uw.trial = 1'b1;
        uw.tbit  = 2'd3;
        uw.jump  = n2a_pkg::J_NEXT;
      end
      n2a_pkg::ST_D_B2: begin
        uw.trial = 1'b1;
        uw.tbit  = 2'd2;
        uw.jump  = n2a_pkg::J_NEXT;
      end
      n2a_pkg::ST_D_B1: begin
        uw.trial = 1'b1;
        uw.tbit  = 2'd1;
        uw.jump  = n2a_pkg::J_NEXT;
      end
      n2a_pkg::ST_D_B0: begin
        uw.trial = 1'b1;
        uw.tbit  = 2'd0;
        uw.jump  = n2a_pkg::J_NEXT;
      end
      n2a_pkg::ST_D_EMIT: begin
        uw.emit   = n2a_pkg::EM_DIGIT;
        uw.sup    = 1'b1;
        uw.jump   = n2a_pkg::J_LOOP;
        uw.target = n2a_pkg::ST_D_B3;
      end
      n2a_pkg::ST_O_EMIT: begin
        uw.emit   = n2a_pkg::EM_DIGIT;
        uw.sup    = 1'b1;
        uw.jump   = n2a_pkg::J_LOOP;
        uw.target = n2a_pkg::ST_O_EMIT;
      end
      n2a_pkg::ST_B_ZERO, n2a_pkg::ST_X_ZERO: begin
        uw.emit = n2a_pkg::EM_LIT;
        uw.lit  = n2a_pkg::CH_ZERO;
        uw.jump = n2a_pkg::J_NEXT;
      end
      n2a_pkg::ST_B_B: begin
        uw.emit = n2a_pkg::EM_LIT;
        uw.lit  = n2a_pkg::CH_LOW_B;
        uw.jump = n2a_pkg::J_NEXT;
      end
      n2a_pkg::ST_X_X: begin
        uw.emit = n2a_pkg::EM_LIT;
        uw.lit  = n2a_pkg::CH_LOW_X;
        uw.jump = n2a_pkg::J_NEXT;
      end
      n2a_pkg::ST_B_BIT: begin
        uw.emit   = n2a_pkg::EM_DIGIT;
        uw.jump   = n2a_pkg::J_LOOP;
        uw.target = n2a_pkg::ST_B_BIT;
      end
      n2a_pkg::ST_X_DIG: begin
        uw.emit   = n2a_pkg::EM_DIGIT;
        uw.jump   = n2a_pkg::J_LOOP;
        uw.target = n2a_pkg::ST_X_DIG;
      end
      default: begin
        uw.jump = n2a_pkg::J_IDLE;
      end
    endcase
  end

endmodule
